// ----- rtl/core/i2a_pkg.sv -----
// shared types, constants and character helper for the integer to ascii text converter
package i2a_pkg;

	// parameter defaults
	localparam int unsigned VALUE_WIDTH_DEF = 32;
	localparam int unsigned MAX_DIGITS_DEF  = 10;

	// fixed field widths
	localparam int unsigned ACTION_W = 2;
	localparam int unsigned IN_W     = 32;
	localparam int unsigned CHAR_W   = 8;
	localparam int unsigned DIGIT_W  = 4;

	// conversion modes
	localparam logic [ACTION_W-1:0] ACT_SDEC = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_UDEC = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_HEX  = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

	// ascii codes
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
	localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
	localparam logic [DIGIT_W-1:0] DIGIT_NINE = 4'd9;
	localparam logic [CHAR_W-1:0]  HEX_BASE   = 8'd10;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [IN_W-1:0]     value;
	} in_item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] out_char;
		logic              last;
	} out_item_t;

	// sequencer to digit unit control
	typedef struct packed {
		logic load;
		logic step;
		logic decimal;
		logic bit_in;
	} i2a_ctrl_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] d_ext;
		d_ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
		if (d <= DIGIT_NINE) begin
			return CH_ZERO + d_ext;
		end else begin
			return CH_LA + d_ext - HEX_BASE;
		end
	endfunction

endpackage

// ----- rtl/core/integer_to_ascii_text.sv -----
// top level: integer to ascii text converter with sequencer and output register
//
//  channel   direction  payload      handshake
//  item      in         in_item_t    item_valid / item_ready
//  text      out        out_item_t   text_valid / text_ready
//
// an item passes the idle state, the shift of its value into the digit unit, the scan past
// leading zeros and the characters: a minus sign for a negative signed value, 0x for hex,
// and then the digits, the last of them with the last flag set
// item_ready is high only while the sequencer is idle; the last character may still
// sit in the output register when the next request is taken
// reset clears the sequencer, the output valid and the overflow flag; no clearing pass
// a stalled text channel holds the sequencer in its current character state
module integer_to_ascii_text #(
	parameter int unsigned VALUE_WIDTH = i2a_pkg::VALUE_WIDTH_DEF,
	parameter int unsigned MAX_DIGITS  = i2a_pkg::MAX_DIGITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  i2a_pkg::in_item_t   item,
	output logic                text_valid,
	input  logic                text_ready,
	output i2a_pkg::out_item_t  text
);
	import i2a_pkg::*;

	localparam int unsigned IDX_W = $clog2(MAX_DIGITS);
	localparam int unsigned CNT_W = $clog2(VALUE_WIDTH + 1);
	localparam int unsigned EXT_W = (VALUE_WIDTH > IN_W) ? VALUE_WIDTH : IN_W;
	localparam logic [IDX_W-1:0] TOP_DEC = IDX_W'(MAX_DIGITS - 1);
	localparam logic [IDX_W-1:0] TOP_HEX = IDX_W'(MAX_DIGITS - 2);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

	// sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CONV  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_SIGN  = 3'd3;
	localparam logic [2:0] S_ZERO  = 3'd4;
	localparam logic [2:0] S_XCHR  = 3'd5;
	localparam logic [2:0] S_DIGIT = 3'd6;

	logic [2:0]             state_q;
	logic [CNT_W-1:0]       bit_cnt_q;
	logic [VALUE_WIDTH-1:0] word_q;
	logic                   neg_q;
	logic                   hex_q;
	logic [IDX_W-1:0]       ptr_q;
	logic                   out_valid_q;
	out_item_t              out_q;

	logic [EXT_W-1:0]       value_ext;
	logic [VALUE_WIDTH-1:0] word_in;
	logic                   word_neg;
	logic                   take;
	logic                   out_free;
	logic                   out_load;
	out_item_t              out_next;
	i2a_ctrl_t              ctrl;
	logic [DIGIT_W-1:0]     rd_digit;
	logic                   overflow;

	assign item_ready = (state_q == S_IDLE);
	assign take       = item_valid && item_ready && (item.action != ACT_NONE);
	assign out_free   = !out_valid_q || text_ready;

	// only the low VALUE_WIDTH bits of the request take part
	assign value_ext = EXT_W'(item.value);
	assign word_in   = value_ext[VALUE_WIDTH-1:0];
	assign word_neg  = (item.action == ACT_SDEC) && word_in[VALUE_WIDTH-1];

	// control to the digit unit
	always_comb begin
		ctrl.load    = take;
		ctrl.step    = (state_q == S_CONV);
		ctrl.decimal = !hex_q;
		ctrl.bit_in  = word_q[VALUE_WIDTH-1];
	end

	i2a_digit_unit #(
		.MAX_DIGITS (MAX_DIGITS),
		.IDX_W      (IDX_W)
	) u_digits (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.rd_idx   (ptr_q),
		.rd_digit (rd_digit),
		.overflow (overflow)
	);

	// character for the current emit state
	always_comb begin
		out_load = 1'b0;
		out_next = '{out_char: CH_ZERO, last: 1'b0};
		unique case (state_q)
			S_SIGN: begin
				out_load          = out_free;
				out_next.out_char = CH_MINUS;
			end
			S_ZERO: begin
				out_load          = out_free;
				out_next.out_char = CH_ZERO;
			end
			S_XCHR: begin
				out_load          = out_free;
				out_next.out_char = CH_X;
			end
			S_DIGIT: begin
				out_load          = out_free;
				out_next.out_char = digit_char(rd_digit);
				out_next.last     = (ptr_q == '0);
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			bit_cnt_q <= '0;
			ptr_q     <= '0;
			neg_q     <= 1'b0;
			hex_q     <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						neg_q     <= word_neg;
						hex_q     <= (item.action == ACT_HEX);
						bit_cnt_q <= CNT_W'(VALUE_WIDTH);
						state_q   <= S_CONV;
					end
				end
				S_CONV: begin
					bit_cnt_q <= bit_cnt_q - CNT_ONE;
					if (bit_cnt_q == CNT_ONE) begin
						ptr_q   <= hex_q ? TOP_HEX : TOP_DEC;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// skip leading zeros unless digits were dropped off the top
					if (!overflow && (ptr_q != '0) && (rd_digit == '0)) begin
						ptr_q <= ptr_q - IDX_W'(1);
					end else if (neg_q) begin
						state_q <= S_SIGN;
					end else if (hex_q) begin
						state_q <= S_ZERO;
					end else begin
						state_q <= S_DIGIT;
					end
				end
				S_SIGN: begin
					if (out_free) begin
						state_q <= hex_q ? S_ZERO : S_DIGIT;
					end
				end
				S_ZERO: begin
					if (out_free) begin
						state_q <= S_XCHR;
					end
				end
				S_XCHR: begin
					if (out_free) begin
						state_q <= S_DIGIT;
					end
				end
				S_DIGIT: begin
					if (out_free) begin
						if (ptr_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							ptr_q <= ptr_q - IDX_W'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// magnitude shift register, msb first into the digit unit
	always_ff @(posedge clk) begin
		if (take) begin
			word_q <= word_neg ? (VALUE_WIDTH'(0) - word_in) : word_in;
		end else if (state_q == S_CONV) begin
			word_q <= word_q << 1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (text_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_next;
		end
	end

	assign text_valid = out_valid_q;
	assign text       = out_q;

	// a real request always starts a conversion
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (state_q == S_CONV))
		else $error("request taken but conversion not started");

	// the final digit leaves with the last flag set
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIGIT && ptr_q == '0 && out_free) |=>
			(text_valid && text.last && state_q == S_IDLE))
		else $error("final digit without last flag");

	// digit pointer stays within the digit register
	a_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_DIGIT) |-> (ptr_q <= TOP_DEC))
		else $error("digit pointer out of range");

	// prefix characters never carry the last flag
	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && state_q != S_DIGIT) |=> !text.last)
		else $error("prefix character marked last");

endmodule

// ----- rtl/core/i2a_digit_unit.sv -----
// digit register with a shift step shared by decimal and hex and an add-three step for decimal
module i2a_digit_unit #(
	parameter int unsigned MAX_DIGITS = i2a_pkg::MAX_DIGITS_DEF,
	parameter int unsigned IDX_W      = $clog2(MAX_DIGITS)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  i2a_pkg::i2a_ctrl_t           ctrl,
	input  logic [IDX_W-1:0]             rd_idx,
	output logic [i2a_pkg::DIGIT_W-1:0]  rd_digit,
	output logic                         overflow
);
	import i2a_pkg::*;

	localparam logic [DIGIT_W-1:0] ADJ_MIN = 4'd5;
	localparam logic [DIGIT_W-1:0] ADJ_ADD = 4'd3;

	logic [DIGIT_W-1:0] digits_q [MAX_DIGITS];
	logic [DIGIT_W-1:0] adj      [MAX_DIGITS];
	logic [DIGIT_W-1:0] shifted  [MAX_DIGITS];
	logic               ovf_q;
	logic               carry;

	// in decimal mode add three to digits of five or more, then shift one bit up the chain
	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (ctrl.decimal && digits_q[i] >= ADJ_MIN) begin
				adj[i] = digits_q[i] + ADJ_ADD;
			end else begin
				adj[i] = digits_q[i];
			end
		end
		shifted[0] = {adj[0][DIGIT_W-2:0], ctrl.bit_in};
		for (int i = 1; i < MAX_DIGITS; i++) begin
			shifted[i] = {adj[i][DIGIT_W-2:0], adj[i-1][DIGIT_W-1]};
		end
		// hex keeps one digit fewer
		carry = ctrl.decimal ? adj[MAX_DIGITS-1][DIGIT_W-1] : adj[MAX_DIGITS-2][DIGIT_W-1];
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			for (int i = 0; i < MAX_DIGITS; i++) begin
				digits_q[i] <= '0;
			end
		end else if (ctrl.step) begin
			for (int i = 0; i < MAX_DIGITS; i++) begin
				digits_q[i] <= shifted[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_q <= 1'b0;
		end else if (ctrl.load) begin
			ovf_q <= 1'b0;
		end else if (ctrl.step) begin
			ovf_q <= ovf_q | carry;
		end
	end

	assign rd_digit = digits_q[rd_idx];
	assign overflow = ovf_q;

endmodule
